FILE: hw/rtl/rfe_pkg.sv
// rfe_pkg: shared constants, command codes, state codes and structs of the
// random fern ensemble classifier. No dependencies.
`default_nettype none

package rfe_pkg;

    localparam int TREES      = 10;
    localparam int LEAF_BITS  = 13;
    localparam int TREE_W     = (TREES > 1) ? $clog2(TREES) : 1;
    localparam int POS_W      = $clog2(TREES + 1);
    localparam int ADDR_W     = TREE_W + LEAF_BITS;
    localparam int DEPTH      = TREES << LEAF_BITS;
    localparam int VOTE_W     = 20;
    localparam int POST_W     = 16;
    localparam int CNT_W      = 16;
    localparam int DIVD_W     = 32;
    localparam int DSR_W      = 17;

    // votes / TREES by reciprocal multiply, exact for any 20-bit vote sum
    localparam int RECIP_SH   = 24;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int PROD_W     = VOTE_W + RECIP_W;
    localparam int QUO_W      = PROD_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + TREES - 1) / TREES);

    localparam logic [POST_W-1:0] THR_RESET = 16'd39322;
    localparam logic [POST_W-1:0] POST_MAX  = 16'hFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;
    // 0.5 per tree, in Q.16
    localparam logic [VOTE_W-1:0] NEG_LIMIT = VOTE_W'(32768 * TREES);

    typedef enum logic [1:0] {
        CMD_CLASSIFY  = 2'd0,
        CMD_TRAIN_POS = 2'd1,
        CMD_TRAIN_NEG = 2'd2,
        CMD_EVAL      = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_DECIDE,
        BK_TR_RD,
        BK_TR_CALC,
        BK_TR_DIV,
        BK_TR_WR,
        BK_OUT
    } back_state_t;

    // one finished sample handed from front to back
    typedef struct packed {
        logic [VOTE_W-1:0]                votes;
        cmd_t                             cmd;
        logic [POS_W-1:0]                 count;
        logic [TREES-1:0][LEAF_BITS-1:0]  leaves;
    } job_t;

    // posterior table write port, driven by the back part
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [POST_W-1:0] data;
    } post_wr_t;

    // back part status seen by the front part
    typedef struct packed {
        logic idle;
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rfe_div.sv
// rfe_div: restoring divider, one quotient bit per cycle; a new start is ignored while busy.
// Depends on rfe_pkg.
`default_nettype none

module rfe_div
    import rfe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0]  divisor,
    output logic                   busy,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    diff;

    // one shift and trial subtract per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[DSR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DSR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rfe_job_fifo.sv
// rfe_job_fifo: two-entry queue of finished samples between front and back.
// Depends on rfe_pkg.
`default_nettype none

module rfe_job_fifo
    import rfe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t job_in,
    input  wire logic pop,
    output job_t      job_out,
    output logic      empty,
    output logic      full
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) mem_reg[wr_ptr_reg] <= job_in;
    end

    assign job_out = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);

endmodule

`default_nettype wire

FILE: hw/rtl/rfe_front.sv
// rfe_front: takes leaf codes, looks up posteriors and sums the votes, then
// queues the finished sample. Holds the posterior table. Depends on rfe_pkg.
`default_nettype none

module rfe_front
    import rfe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cmd_t                 in_cmd,
    input  wire logic [LEAF_BITS-1:0] in_leaf,
    input  wire logic                 in_last,
    input  wire post_wr_t             post_wr,
    input  wire back_status_t         back_st,
    input  wire logic                 fifo_empty,
    output logic                      job_push,
    output job_t                      job
);

    logic [POST_W-1:0] post_mem [DEPTH];
    logic [POST_W-1:0] rd_data_reg;

    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [VOTE_W-1:0]               sum_reg, sum_next;
    logic [TREES-1:0][LEAF_BITS-1:0] buf_reg, buf_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic                            pend_read_reg, pend_read_next;
    logic                            pend_last_reg, pend_last_next;
    cmd_t                            pend_cmd_reg, pend_cmd_next;
    logic [POS_W-1:0]                pend_count_reg, pend_count_next;
    logic                            fire;
    logic                            rd_en;
    logic [ADDR_W-1:0]               rd_addr;
    logic [VOTE_W-1:0]               sum_add;

    // a new sample starts only once the back part has finished all training
    assign in_ready = !back_st.clearing &&
                      ((pos_reg != '0) || (back_st.idle && fifo_empty && !pend_valid_reg));
    assign fire     = in_valid && in_ready;
    assign rd_addr  = {pos_reg[TREE_W-1:0], in_leaf};

    // accept, look up, accumulate in the next cycle
    always_comb begin
        pos_next        = pos_reg;
        buf_next        = buf_reg;
        rd_en           = 1'b0;
        pend_valid_next = fire;
        pend_read_next  = 1'b0;
        pend_last_next  = in_last;
        pend_cmd_next   = in_cmd;
        pend_count_next = pend_count_reg;
        if (fire) begin
            if (pos_reg < POS_W'(TREES)) begin
                buf_next[pos_reg[TREE_W-1:0]] = in_leaf;
                rd_en          = 1'b1;
                pend_read_next = 1'b1;
                pos_next       = pos_reg + 1'b1;
            end
            pend_count_next = pos_next;
            if (in_last) pos_next = '0;
        end
        sum_add  = sum_reg + (pend_read_reg ? VOTE_W'(rd_data_reg) : '0);
        sum_next = sum_reg;
        job_push = 1'b0;
        if (pend_valid_reg) begin
            sum_next = pend_last_reg ? '0 : sum_add;
            job_push = pend_last_reg;
        end
        job.votes  = sum_add;
        job.cmd    = pend_cmd_reg;
        job.count  = pend_count_reg;
        job.leaves = buf_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            sum_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            pend_valid_reg <= pend_valid_next;
        end
        buf_reg        <= buf_next;
        pend_read_reg  <= pend_read_next;
        pend_last_reg  <= pend_last_next;
        pend_cmd_reg   <= pend_cmd_next;
        pend_count_reg <= pend_count_next;
    end

    // posterior table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (post_wr.en) post_mem[post_wr.addr] <= post_wr.data;
        if (rd_en) rd_data_reg <= post_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rfe_back.sv
// rfe_back: clears the tables, decides training, updates counters and
// posteriors, tracks the threshold and drives the result word.
// Depends on rfe_pkg and rfe_div.
`default_nettype none

module rfe_back
    import rfe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [POST_W-1:0] cfg_data,
    input  wire logic              fifo_empty,
    output logic                   fifo_pop,
    input  wire job_t              fifo_job,
    output post_wr_t               post_wr,
    output back_status_t           status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [VOTE_W-1:0]      out_votes,
    output logic                   out_trained,
    output logic [POST_W-1:0]      out_thr
);

    logic [2*CNT_W-1:0] cnt_mem [DEPTH];
    logic [2*CNT_W-1:0] cnt_rd_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    job_t              job_reg, job_next;
    logic [POS_W-1:0]  t_reg, t_next;
    logic              train_reg, train_next;
    logic [POST_W-1:0] post_reg, post_next;
    logic [POST_W-1:0] thr_reg, thr_next;
    logic              ov_reg, ov_next;
    logic [VOTE_W-1:0] ovotes_reg, ovotes_next;
    logic              otrained_reg, otrained_next;
    logic [POST_W-1:0] othr_reg, othr_next;

    logic               cnt_rd_en;
    logic               cnt_wr_en;
    logic [ADDR_W-1:0]  cnt_addr;
    logic [ADDR_W-1:0]  tr_addr;
    logic [2*CNT_W-1:0] cnt_wr_data;
    logic [CNT_W-1:0]   p_old, n_old, p_new, n_new;
    logic               is_pos;
    logic [VOTE_W-1:0]  pos_limit;
    logic [POST_W-1:0]  q_sat;
    logic [PROD_W-1:0]  ev_prod;
    logic [QUO_W-1:0]   ev_quo;
    logic [POST_W-1:0]  ev_q;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DSR_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    rfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign tr_addr   = {t_reg[TREE_W-1:0], job_reg.leaves[t_reg[TREE_W-1:0]]};
    assign is_pos    = (job_reg.cmd == CMD_TRAIN_POS);
    assign pos_limit = VOTE_W'(32'(thr_reg) * TREES);
    assign p_old     = cnt_rd_reg[2*CNT_W-1:CNT_W];
    assign n_old     = cnt_rd_reg[CNT_W-1:0];
    assign q_sat     = (div_q > DIVD_W'(POST_MAX)) ? POST_MAX : div_q[POST_W-1:0];

    // evaluate: mean vote per tree, saturated to Q0.16
    assign ev_prod = PROD_W'(job_reg.votes) * PROD_W'(RECIP);
    assign ev_quo  = ev_prod[PROD_W-1:RECIP_SH];
    assign ev_q    = (ev_quo > QUO_W'(POST_MAX)) ? POST_MAX : ev_quo[POST_W-1:0];

    // saturating counter bump
    always_comb begin
        p_new = p_old;
        n_new = n_old;
        if (is_pos) begin
            if (p_old != CNT_MAX) p_new = p_old + 1'b1;
        end else begin
            if (n_old != CNT_MAX) n_new = n_old + 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        job_next      = job_reg;
        t_next        = t_reg;
        train_next    = train_reg;
        post_next     = post_reg;
        thr_next      = thr_reg;
        ov_next       = ov_reg && !out_ready;
        ovotes_next   = ovotes_reg;
        otrained_next = otrained_reg;
        othr_next     = othr_reg;
        fifo_pop      = 1'b0;
        cnt_rd_en     = 1'b0;
        cnt_wr_en     = 1'b0;
        cnt_addr      = tr_addr;
        cnt_wr_data   = {p_new, n_new};
        post_wr.en    = 1'b0;
        post_wr.addr  = tr_addr;
        post_wr.data  = post_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        unique case (state_reg)
            BK_CLEAR: begin
                cnt_wr_en    = 1'b1;
                cnt_addr     = clr_reg;
                cnt_wr_data  = '0;
                post_wr.en   = 1'b1;
                post_wr.addr = clr_reg;
                post_wr.data = '0;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (!fifo_empty) begin
                    fifo_pop   = 1'b1;
                    job_next   = fifo_job;
                    state_next = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                t_next = '0;
                priority case (job_reg.cmd)
                    CMD_TRAIN_POS: train_next = (job_reg.votes <= pos_limit);
                    CMD_TRAIN_NEG: train_next = (job_reg.votes >= NEG_LIMIT);
                    default:       train_next = 1'b0;
                endcase
                if (job_reg.cmd == CMD_EVAL) begin
                    if (ev_q > thr_reg) thr_next = ev_q;
                    state_next = BK_OUT;
                end else if (train_next && (job_reg.count != '0)) begin
                    state_next = BK_TR_RD;
                end else begin
                    state_next = BK_OUT;
                end
            end
            BK_TR_RD: begin
                cnt_rd_en  = 1'b1;
                state_next = BK_TR_CALC;
            end
            BK_TR_CALC: begin
                cnt_wr_en    = 1'b1;
                div_dividend = {p_new, 16'b0};
                div_divisor  = DSR_W'(p_new) + DSR_W'(n_new);
                if (p_new == '0) begin
                    post_next  = '0;
                    state_next = BK_TR_WR;
                end else begin
                    div_start  = 1'b1;
                    state_next = BK_TR_DIV;
                end
            end
            BK_TR_DIV: begin
                if (div_done) begin
                    post_next  = q_sat;
                    state_next = BK_TR_WR;
                end
            end
            BK_TR_WR: begin
                post_wr.en = 1'b1;
                t_next     = t_reg + 1'b1;
                state_next = (t_next == job_reg.count) ? BK_OUT : BK_TR_RD;
            end
            BK_OUT: begin
                if (!ov_reg || out_ready) begin
                    ov_next       = 1'b1;
                    ovotes_next   = job_reg.votes;
                    otrained_next = train_reg;
                    othr_next     = thr_reg;
                    state_next    = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
        // register write reloads the threshold
        if (cfg_valid) thr_next = cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            thr_reg   <= THR_RESET;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            thr_reg   <= thr_next;
            ov_reg    <= ov_next;
        end
        job_reg      <= job_next;
        t_reg        <= t_next;
        train_reg    <= train_next;
        post_reg     <= post_next;
        ovotes_reg   <= ovotes_next;
        otrained_reg <= otrained_next;
        othr_reg     <= othr_next;
    end

    // counter table {p, n}: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cnt_wr_en) cnt_mem[cnt_addr] <= cnt_wr_data;
        if (cnt_rd_en) cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    assign status.idle     = (state_reg == BK_IDLE);
    assign status.clearing = (state_reg == BK_CLEAR);
    assign out_valid       = ov_reg;
    assign out_votes       = ovotes_reg;
    assign out_trained     = otrained_reg;
    assign out_thr         = othr_reg;

    // no result while the tables are being swept
    a_no_out_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !ov_reg)
        else $error("result word during clearing pass");

    // divider is only started when free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // threshold only drops on a register write
    a_thr_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_valid |=> (thr_reg >= $past(thr_reg)))
        else $error("threshold decreased without a register write");

    // counter writes only in the sweep or the update step
    a_cnt_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_wr_en |-> ((state_reg == BK_CLEAR) || (state_reg == BK_TR_CALC)))
        else $error("stray counter table write");

endmodule

`default_nettype wire

FILE: hw/rtl/random_fern_ensemble_classifier_unit.sv
// Random fern ensemble classifier. Leaf codes go in one word per cycle while
// s_tready is high; a sample that trains walks each of its trees through counter
// read, update, divide (skipped when the positive count stays zero; 32-step
// divider) and posterior write before its result. The next sample is taken
// once the back part is idle again. Reset (aresetn, synchronous, active low)
// starts a clearing pass over all 81920 entries of the count and posterior
// tables; no word is taken during it.
`default_nettype none

module random_fern_ensemble_classifier_unit
    import rfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [12:0] leaf, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    input  wire logic        s_tlast,   // last code of the sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [19:0] votes, [35:20] fern_threshold, rest zero
    output logic             m_tuser,   // [0] trained
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // fern_threshold_init
);

    post_wr_t          post_wr;
    back_status_t      back_st;
    logic              fifo_empty;
    logic              fifo_full;
    logic              job_push;
    logic              fifo_pop;
    job_t              job_in;
    job_t              job_out;
    logic [VOTE_W-1:0] out_votes;
    logic [POST_W-1:0] out_thr;

    assign cfg_ready = 1'b1;

    rfe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser)),
        .in_leaf    (s_tdata[LEAF_BITS-1:0]),
        .in_last    (s_tlast),
        .post_wr    (post_wr),
        .back_st    (back_st),
        .fifo_empty (fifo_empty),
        .job_push   (job_push),
        .job        (job_in)
    );

    rfe_job_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push && !fifo_full),
        .job_in  (job_in),
        .pop     (fifo_pop),
        .job_out (job_out),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    rfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .fifo_empty  (fifo_empty),
        .fifo_pop    (fifo_pop),
        .fifo_job    (job_out),
        .post_wr     (post_wr),
        .status      (back_st),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_votes   (out_votes),
        .out_trained (m_tuser),
        .out_thr     (out_thr)
    );

    assign m_tdata = {4'b0, out_thr, out_votes};

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking bench for random_fern_ensemble_classifier_unit.
// Needs rfe_pkg and the unit; leaf words stream in, verdict words are checked.
`timescale 1ns / 1ps

module tb_top;
    import rfe_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 600;

    typedef struct {
        cmd_t            cmd;
        bit [12:0]       leaf;
        bit              last;
    } leaf_word_t;

    typedef struct {
        bit [19:0] votes;
        bit        trained;
        bit [15:0] thr;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    random_fern_ensemble_classifier_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    leaf_word_t  pending_words[$];
    verdict_t    expected_verdicts[$];
    int          fail_count = 0;
    bit          quiet_mode = 1'b0;

    // fern model state
    bit [15:0] pos_cnt [DEPTH];
    bit [15:0] neg_cnt [DEPTH];
    bit [15:0] post_tab[DEPTH];
    bit [12:0] leaf_buf[TREES];
    int        fill_pos = 0;
    bit [19:0] vote_acc = '0;
    bit [15:0] thr_now = THR_RESET;

    // bump one counter pair and recompute its posterior
    task automatic bump_leaf(input int idx, input bit positive);
        longint p, n, q;
        if (positive) begin
            if (pos_cnt[idx] != 16'hFFFF) pos_cnt[idx]++;
        end else begin
            if (neg_cnt[idx] != 16'hFFFF) neg_cnt[idx]++;
        end
        p = pos_cnt[idx];
        n = neg_cnt[idx];
        if (p == 0) q = 0;
        else q = (p << 16) / (p + n);
        if (q > 65535) q = 65535;
        post_tab[idx] = q[15:0];
    endtask

    // advance the model by one accepted leaf word
    task automatic fern_absorb(input leaf_word_t w);
        verdict_t v;
        int       count;
        bit       do_train;
        longint   q;
        if (fill_pos < TREES) begin
            leaf_buf[fill_pos] = w.leaf;
            vote_acc = vote_acc + post_tab[fill_pos * (1 << LEAF_BITS) + w.leaf];
            fill_pos++;
        end
        if (!w.last) return;
        count    = fill_pos;
        v.votes  = vote_acc;
        fill_pos = 0;
        vote_acc = '0;
        do_train = 1'b0;
        case (w.cmd)
            CMD_TRAIN_POS: do_train = longint'(v.votes) <= longint'(thr_now) * TREES;
            CMD_TRAIN_NEG: do_train = longint'(v.votes) >= 64'd32768 * TREES;
            CMD_EVAL: begin
                q = longint'(v.votes) / TREES;
                if (q > 65535) q = 65535;
                if (q > thr_now) thr_now = q[15:0];
            end
            default: ;
        endcase
        if (do_train)
            for (int t = 0; t < count; t++)
                bump_leaf(t * (1 << LEAF_BITS) + leaf_buf[t], w.cmd == CMD_TRAIN_POS);
        v.trained = do_train;
        v.thr     = thr_now;
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    // mostly no gap, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // leaf word driver
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                fern_absorb('{cmd_t'(s_tuser), s_tdata[12:0], s_tlast});
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                leaf_word_t w;
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, w.leaf};
                s_tuser  <= w.cmd;
                s_tlast  <= w.last;
                gap_left = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // verdict monitor
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                verdict_t e;
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected verdict word %h", m_tdata);
                    fail_count++;
                end else begin
                    e = expected_verdicts.pop_front();
                    if (m_tdata[19:0] !== e.votes) begin
                        $error("votes exp %0d got %0d", e.votes, m_tdata[19:0]);
                        fail_count++;
                    end
                    if (m_tuser !== e.trained) begin
                        $error("trained exp %0d got %0d", e.trained, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[35:20] !== e.thr) begin
                        $error("fern_threshold exp %0d got %0d", e.thr, m_tdata[35:20]);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // run watchdog
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_word(input cmd_t c, input bit [12:0] lf, input bit lst);
        leaf_word_t w;
        w = '{c, lf, lst};
        pending_words.insert(pending_words.size(), w);
    endtask

    // wait until every word is sent and every verdict is back, then settle
    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_threshold(input bit [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        thr_now = value;
        cfg_valid <= 1'b0;
    endtask

    bit [12:0] pattern_bank[4][TREES];

    // one random sample; mostly a stored pattern so tables fill up
    task automatic random_sample();
        int   pat, len, r;
        cmd_t final_cmd;
        pat = $urandom_range(0, 3);
        r   = $urandom_range(0, 99);
        len = (r < 90) ? TREES : (r < 95) ? $urandom_range(1, TREES - 1)
                                          : $urandom_range(TREES + 1, TREES + 3);
        r = $urandom_range(0, 99);
        final_cmd = (r < 20) ? CMD_CLASSIFY : (r < 55) ? CMD_TRAIN_POS :
                    (r < 85) ? CMD_TRAIN_NEG : CMD_EVAL;
        for (int t = 0; t < len; t++) begin
            bit [12:0] lf;
            lf = ($urandom_range(0, 99) < 85 && t < TREES) ? pattern_bank[pat][t]
                                                            : 13'($urandom);
            if (t == len - 1) add_word(final_cmd, lf, 1'b1);
            else add_word(cmd_t'($urandom_range(0, 3)), lf, 1'b0);
        end
    endtask

    bit [15:0] phase_thr[4] = '{16'd0, 16'hFFFF, 16'd0, THR_RESET};

    initial begin
        for (int p = 0; p < 4; p++)
            for (int t = 0; t < TREES; t++)
                pattern_bank[p][t] = (p == 0) ? 13'h1FFF : 13'($urandom);
        phase_thr[2] = 16'($urandom);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full train-positive sample with mixed commands
        for (int t = 0; t < TREES; t++)
            add_word(t == TREES - 1 ? CMD_TRAIN_POS : cmd_t'(t % 4),
                     (t % 2) ? 13'h1FFF : 13'h0000, t == TREES - 1);
        // short negative, single-code classify and evaluate
        add_word(CMD_CLASSIFY, 13'h1FFF, 1'b0);
        add_word(CMD_TRAIN_NEG, 13'h0000, 1'b1);
        add_word(CMD_CLASSIFY, 13'h0000, 1'b1);
        add_word(CMD_EVAL, 13'h0000, 1'b1);
        // long sample, extra codes dropped
        for (int t = 0; t < TREES + 1; t++)
            add_word(t == TREES ? CMD_EVAL : CMD_TRAIN_NEG,
                     (t % 2) ? 13'h1FFF : 13'h0000, t == TREES);
        drain();

        // random phases, threshold rewritten between them
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(phase_thr[ph]);
            quiet_mode = (ph == 2);
            while (pending_words.size() < 260) random_sample();
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
